// File: sv/bce_pkg.sv
// Shared types, constants and helpers for the Bezier curve evaluator.
// No dependencies; imported by bezier_curve_evaluator.
`timescale 1ns / 1ps
`default_nettype none

package bce_pkg;

    localparam int unsigned MAX_POINTS_DEF   = 32;
    localparam int unsigned COUNT_W          = 6;
    localparam int unsigned INDEX_W          = 5;
    localparam int unsigned COORD_W          = 32;
    localparam int unsigned T_W              = 17;
    localparam logic [COUNT_W-1:0] POINT_COUNT_RST = 6'd21;
    localparam logic [T_W-1:0]     T_ONE           = 17'd65536;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_FETCH_P = 6'b000010,
        S_LOAD_P  = 6'b000100,
        S_MUL_X   = 6'b001000,
        S_MUL_Y   = 6'b010000,
        S_WRITE   = 6'b100000
    } state_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

    // Clamp a sum to the signed 32-bit range.
    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [35:0] v);
        logic signed [35:0] hi;
        logic signed [35:0] lo;
        hi = 36'sd2147483647;
        lo = -36'sd2147483648;
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[COORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: sv/bezier_curve_evaluator.sv
// Bezier curve evaluator: point store, de Casteljau scratch row and sequencer.
// Depends on bce_pkg.
// A load beat writes the point store when accepted. An evaluate beat works on
//   n = clamped point_count points until the result register is loaded, using
//   one shared 33x18 multiplier and adder that handle each interpolation as
//   x then y.
// One beat is worked at a time; s_ready is high only in the idle state.
// Reset (aresetn, synchronous, active low) clears the sequencer, the output
//   valid and sets point_count to 21; point and scratch stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module bezier_curve_evaluator
    import bce_pkg::*;
#(
    parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,

    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [COUNT_W-1:0]          cfg_point_count,

    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_func,
    input  wire logic [INDEX_W-1:0]          s_point_index,
    input  wire logic signed [COORD_W-1:0]   s_point_x,
    input  wire logic signed [COORD_W-1:0]   s_point_y,
    input  wire logic [T_W-1:0]              s_t_param,

    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic signed [COORD_W-1:0]        m_curve_x,
    output logic signed [COORD_W-1:0]        m_curve_y
);

    // Address width of the stores and width of a count that can hold MAX_POINTS.
    localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int unsigned CW = $clog2(MAX_POINTS + 1);

    // ------------------------------------------------------------------
    // Configuration register. The user must issue writes only while idle; the
    // block does not enforce this. The port is always ready.
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0] point_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_count_reg <= POINT_COUNT_RST;
        end else if (cfg_valid) begin
            point_count_reg <= cfg_point_count;
        end
    end

    // Point count actually used: clamped to 2..MAX_POINTS.
    logic [CW-1:0] n_eff;
    always_comb begin
        if (point_count_reg < COUNT_W'(2)) begin
            n_eff = CW'(2);
        end else if (int'(point_count_reg) > int'(MAX_POINTS)) begin
            n_eff = CW'(MAX_POINTS);
        end else begin
            n_eff = CW'(point_count_reg);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state.
    // ------------------------------------------------------------------
    state_t             state_reg, state_next;
    logic [AW-1:0]      i_reg, i_next;           // entry being rewritten in this row
    logic [AW-1:0]      last_reg, last_next;     // last entry of the current row
    logic               first_row_reg, first_row_next;
    logic [T_W-1:0]     t_reg;

    logic in_beat;
    logic load_beat;
    logic eval_beat;
    logic row_end;
    logic final_step;
    logic out_free;

    assign s_ready   = (state_reg == S_IDLE);
    assign in_beat   = s_valid && s_ready;
    assign load_beat = in_beat && (s_func == FUNC_LOAD);
    assign eval_beat = in_beat && (s_func == FUNC_EVAL);
    assign row_end   = (i_reg == last_reg);
    assign final_step = row_end && (last_reg == '0);
    // The result register can take a new result once the old one is gone.
    assign out_free  = !m_valid || m_ready;

    // ------------------------------------------------------------------
    // Point store (written by load beats) and scratch row. Both are
    // single-port-read memories with registered read data.
    // ------------------------------------------------------------------
    point_t ctrl_mem [MAX_POINTS];
    point_t work_mem [MAX_POINTS];
    point_t ctrl_rd_reg;
    point_t work_rd_reg;
    point_t rd_pt;
    point_t ld_pt;
    point_t wr_pt;

    logic [AW-1:0] ld_addr;
    logic          ld_we;
    logic [AW-1:0] rd_addr;
    logic          wr_we;

    assign ld_addr = AW'(s_point_index);
    assign ld_we   = load_beat && (int'(s_point_index) < int'(MAX_POINTS));
    assign ld_pt.x = s_point_x;
    assign ld_pt.y = s_point_y;

    always_ff @(posedge aclk) begin
        if (ld_we) begin
            ctrl_mem[ld_addr] <= ld_pt;
        end
        ctrl_rd_reg <= ctrl_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (wr_we) begin
            work_mem[i_reg] <= wr_pt;
        end
        work_rd_reg <= work_mem[rd_addr];
    end

    // The first row reads the control points directly; later rows read the
    // scratch row written by the row before.
    assign rd_pt = first_row_reg ? ctrl_rd_reg : work_rd_reg;

    // Read address: entry 0 at the start of a row, then the right-hand
    // neighbor of each entry one step ahead of its use.
    always_comb begin
        case (state_reg)
            S_FETCH_P: rd_addr = '0;
            S_LOAD_P:  rd_addr = AW'(1);
            S_WRITE:   rd_addr = row_end ? '0 : AW'(i_reg + AW'(2));
            default:   rd_addr = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Shared interpolation unit: one subtract-multiply stage feeding a
    // product register, then one add-and-saturate stage. Each step
    // computes p + floor((q - p) * t / 65536) for x, then for y.
    // ------------------------------------------------------------------
    point_t p_reg;
    point_t q_reg;
    logic signed [COORD_W-1:0] res_x_reg;

    logic signed [COORD_W-1:0] mul_min;
    logic signed [COORD_W-1:0] mul_sub;
    logic signed [32:0]        mul_a;
    logic signed [17:0]        mul_b;
    logic signed [50:0]        prod_reg, prod_next;
    logic signed [34:0]        prod_sh;
    logic signed [COORD_W-1:0] add_base;
    logic signed [35:0]        add_sum;
    logic signed [COORD_W-1:0] add_sat;

    always_comb begin
        if (state_reg == S_MUL_Y) begin
            mul_min = q_reg.y;
            mul_sub = p_reg.y;
        end else begin
            mul_min = rd_pt.x;
            mul_sub = p_reg.x;
        end
    end

    assign mul_a     = 33'(mul_min) - 33'(mul_sub);
    assign mul_b     = {1'b0, t_reg};
    assign prod_next = 51'(mul_a) * 51'(mul_b);

    // Arithmetic shift right by 16 is the floor of the quotient.
    assign prod_sh  = prod_reg[50:16];
    assign add_base = (state_reg == S_WRITE) ? p_reg.y : p_reg.x;
    assign add_sum  = 36'(add_base) + 36'(prod_sh);
    assign add_sat  = sat32(add_sum);

    assign wr_pt.x = res_x_reg;
    assign wr_pt.y = add_sat;
    assign wr_we   = (state_reg == S_WRITE);

    always_ff @(posedge aclk) begin
        if (eval_beat) begin
            t_reg <= (s_t_param > T_ONE) ? T_ONE : s_t_param;
        end
        case (state_reg)
            S_LOAD_P: begin
                p_reg <= rd_pt;
            end
            S_MUL_X: begin
                q_reg    <= rd_pt;
                prod_reg <= prod_next;
            end
            S_MUL_Y: begin
                res_x_reg <= add_sat;
                prod_reg  <= prod_next;
            end
            S_WRITE: begin
                // The new right neighbor becomes the left point of the next step.
                if (!row_end) begin
                    p_reg <= q_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: one row of de Casteljau at a time, each row one entry
    // shorter, until a single point is left.
    // ------------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        i_next         = i_reg;
        last_next      = last_reg;
        first_row_next = first_row_reg;
        case (state_reg)
            S_IDLE: begin
                if (eval_beat) begin
                    state_next     = S_FETCH_P;
                    i_next         = '0;
                    last_next      = AW'(n_eff - CW'(2));
                    first_row_next = 1'b1;
                end
            end
            S_FETCH_P: begin
                state_next = S_LOAD_P;
            end
            S_LOAD_P: begin
                state_next = S_MUL_X;
            end
            S_MUL_X: begin
                state_next = S_MUL_Y;
            end
            S_MUL_Y: begin
                state_next = S_WRITE;
            end
            S_WRITE: begin
                if (!row_end) begin
                    state_next = S_MUL_X;
                    i_next     = i_reg + AW'(1);
                end else if (!final_step) begin
                    state_next     = S_FETCH_P;
                    i_next         = '0;
                    last_next      = last_reg - AW'(1);
                    first_row_next = 1'b0;
                end else if (out_free) begin
                    // Hold the final step until the result register is free.
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            i_reg         <= '0;
            last_reg      <= '0;
            first_row_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            last_reg      <= last_next;
            first_row_reg <= first_row_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register. It holds a finished point while the next beat is
    // accepted and worked on.
    // ------------------------------------------------------------------
    logic                      m_valid_reg;
    logic signed [COORD_W-1:0] m_curve_x_reg;
    logic signed [COORD_W-1:0] m_curve_y_reg;
    logic                      result_done;

    assign result_done = (state_reg == S_WRITE) && final_step && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (result_done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (result_done) begin
            m_curve_x_reg <= wr_pt.x;
            m_curve_y_reg <= wr_pt.y;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_curve_x = m_curve_x_reg;
    assign m_curve_y = m_curve_y_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // An evaluate beat starts the first row with the full clamped length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        eval_beat |=> (state_reg == S_FETCH_P) && first_row_reg && (i_reg == '0)
                      && (last_reg == AW'($past(n_eff) - CW'(2))))
    else $error("evaluate beat did not start the first row correctly");

    // The entry index never runs past the end of its row.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> (i_reg <= last_reg))
    else $error("row index ran past the end of the row");

    // A finished point waits while the previous result is still held.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_WRITE) && final_step && m_valid && !m_ready)
        |=> (state_reg == S_WRITE) && m_valid)
    else $error("final step did not wait for the result register");

    // A load beat causes no work and no result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (load_beat && !m_valid) |=> (state_reg == S_IDLE) && !m_valid)
    else $error("load beat started work or produced a result");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for bezier_curve_evaluator: control point loads, curve evaluations
// and point_count writes, checked against an in-bench de Casteljau predictor.
// Depends on bce_pkg and bezier_curve_evaluator.
`timescale 1ns / 1ps

module tb_top;
    import bce_pkg::*;

    localparam int unsigned NPTS        = MAX_POINTS_DEF;
    localparam int unsigned IDLE_PCT    = 9;
    // The slowest beat is an evaluation at 32 points plus a short receiver stall.
    // Many times that with nothing accepted means the block is hung.
    localparam int unsigned STALL_LIMIT = 20000;
    localparam int unsigned N_PHASES    = 13;

    // point_count used by each random phase, first entry on the right. The list covers
    // both ends of the range, the values below it and above it that get clamped, and
    // the all-zeros and all-ones register patterns.
    localparam logic [N_PHASES-1:0][COUNT_W-1:0] COUNT_SEQ = {
        6'd7, 6'd21, 6'd6, 6'd4, 6'd33, 6'd3, 6'd8, 6'd63, 6'd1, 6'd5, 6'd0, 6'd32, 6'd2
    };

    typedef struct packed {
        logic                      func;
        logic [INDEX_W-1:0]        index;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [T_W-1:0]            t;
    } beat_t;

    logic                      aclk            = 1'b0;
    logic                      aresetn         = 1'b0;
    logic                      cfg_valid       = 1'b0;
    logic                      cfg_ready;
    logic [COUNT_W-1:0]        cfg_point_count = '0;
    logic                      s_valid         = 1'b0;
    logic                      s_ready;
    logic                      s_func          = FUNC_LOAD;
    logic [INDEX_W-1:0]        s_point_index   = '0;
    logic signed [COORD_W-1:0] s_point_x       = '0;
    logic signed [COORD_W-1:0] s_point_y       = '0;
    logic [T_W-1:0]            s_t_param       = '0;
    logic                      m_valid;
    logic                      m_ready         = 1'b0;
    logic signed [COORD_W-1:0] m_curve_x;
    logic signed [COORD_W-1:0] m_curve_y;

    // Beats waiting to be driven, and curve points waiting to come out of the block.
    beat_t  beat_q[$];
    point_t curve_q[$];

    // Predictor state: the bench's own copy of the point store and of point_count.
    logic signed [COORD_W-1:0] ctrl_x [NPTS];
    logic signed [COORD_W-1:0] ctrl_y [NPTS];
    logic signed [COORD_W-1:0] row_x  [NPTS];
    logic signed [COORD_W-1:0] row_y  [NPTS];
    logic [COUNT_W-1:0]        count_now = POINT_COUNT_RST;

    // Which store entries the stimulus has loaded so far. An evaluation is only
    // queued once every entry it reads has been loaded.
    logic [NPTS-1:0] gen_loaded = '0;

    beat_t       cur_beat;
    logic        steady     = 1'b0;
    int unsigned err_count  = 0;
    int unsigned quiet_cnt  = 0;

    bezier_curve_evaluator DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_point_count (cfg_point_count),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_point_index   (s_point_index),
        .s_point_x       (s_point_x),
        .s_point_y       (s_point_y),
        .s_t_param       (s_t_param),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_curve_x       (m_curve_x),
        .m_curve_y       (m_curve_y)
    );

    always #2 aclk = ~aclk;

    // One de Casteljau step: p + floor((q - p) * t / 65536), clamped to 32 bits.
    // The difference needs 33 bits and the product 50, so 64-bit math is exact.
    function automatic logic signed [COORD_W-1:0] blend(
        input logic signed [COORD_W-1:0] p,
        input logic signed [COORD_W-1:0] q,
        input logic [T_W-1:0]            t
    );
        longint diff;
        longint sum;
        diff = longint'(q) - longint'(p);
        sum  = longint'(p) + ((diff * longint'(t)) >>> 16);
        if (sum > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (sum < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return sum[COORD_W-1:0];
    endfunction

    // Coordinates: mostly full-range random, some near zero so that neighboring
    // points are close, and some at the two extremes.
    function automatic logic signed [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0: begin
                return 32'sh7FFF_FFFF;
            end
            1: begin
                return 32'sh8000_0000;
            end
            2, 3, 4: begin
                return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    // Parameters: mostly inside [0, 1.0], some above 1.0 where the block saturates,
    // and some exactly on the corners.
    function automatic logic [T_W-1:0] pick_t();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 5))
                    0:       return '0;
                    1:       return 17'd1;
                    2:       return T_ONE - 17'd1;
                    3:       return T_ONE;
                    4:       return T_ONE + 17'd1;
                    default: return '1;
                endcase
            end
            1: begin
                return T_W'($urandom_range(T_ONE + 1, 17'h1FFFF));
            end
            default: begin
                return T_W'($urandom_range(0, T_ONE));
            end
        endcase
    endfunction

    task automatic add_load(
        input int unsigned               idx,
        input logic signed [COORD_W-1:0] x,
        input logic signed [COORD_W-1:0] y
    );
        beat_t b;
        b.func          = FUNC_LOAD;
        b.index         = idx[INDEX_W-1:0];
        b.x             = x;
        b.y             = y;
        b.t             = T_W'($urandom);
        gen_loaded[idx] = 1'b1;
        beat_q.push_back(b);
    endtask

    task automatic add_eval(input logic [T_W-1:0] t);
        beat_t b;
        b.func  = FUNC_EVAL;
        b.index = INDEX_W'($urandom);
        b.x     = $urandom;
        b.y     = $urandom;
        b.t     = t;
        beat_q.push_back(b);
    endtask

    // Hold off until every queued beat is in and every curve point is out. The check
    // is made at the falling edge, after the sender has settled its rising-edge work.
    // A load gives no result, so the task then lets a trailing load finish before the
    // block is treated as idle.
    task automatic drain();
        do @(negedge aclk); while (beat_q.size() != 0 || s_valid || curve_q.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Sender. A new beat goes on the bus only when the slot is free: nothing is
    // driven, or the beat on the bus is taken at this edge. A taken beat updates
    // the predictor; an evaluation queues the curve point that should come out.
    always @(posedge aclk) begin
        int unsigned n;
        logic [T_W-1:0] t;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                if (cur_beat.func == FUNC_LOAD) begin
                    ctrl_x[cur_beat.index] = cur_beat.x;
                    ctrl_y[cur_beat.index] = cur_beat.y;
                end else begin
                    // point_count is clamped to 2..32 and t to 1.0 before use.
                    n = 32'(count_now);
                    if (n < 2) n = 2;
                    if (n > NPTS) n = NPTS;
                    t = (cur_beat.t > T_ONE) ? T_ONE : cur_beat.t;
                    for (int i = 0; i < n; i++) begin
                        row_x[i] = ctrl_x[i];
                        row_y[i] = ctrl_y[i];
                    end
                    // Each pass shortens the row by one; row[0] ends as the curve point.
                    for (int r = 1; r < n; r++) begin
                        for (int i = 0; i + r < n; i++) begin
                            row_x[i] = blend(row_x[i], row_x[i + 1], t);
                            row_y[i] = blend(row_y[i], row_y[i + 1], t);
                        end
                    end
                    curve_q.push_back('{x: row_x[0], y: row_y[0]});
                end
            end
            if (beat_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                cur_beat      = beat_q.pop_front();
                s_valid       <= 1'b1;
                s_func        <= cur_beat.func;
                s_point_index <= cur_beat.index;
                s_point_x     <= cur_beat.x;
                s_point_y     <= cur_beat.y;
                s_t_param     <= cur_beat.t;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver. Each curve point taken is checked against the oldest expected one.
    // m_ready drops about 9 percent of the time, except in the steady phase.
    always @(posedge aclk) begin
        point_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (curve_q.size() == 0) begin
                    $display("%0t: curve point (%0d, %0d) with no evaluation pending",
                             $time, m_curve_x, m_curve_y);
                    err_count++;
                end else begin
                    want = curve_q.pop_front();
                    if (m_curve_x !== want.x) begin
                        $display("%0t: curve_x expected %0d, got %0d",
                                 $time, want.x, m_curve_x);
                        err_count++;
                    end
                    if (m_curve_y !== want.y) begin
                        $display("%0t: curve_y expected %0d, got %0d",
                                 $time, want.y, m_curve_y);
                        err_count++;
                    end
                end
            end
            m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: any beat on any channel restarts the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cnt <= 0;
        end else if (quiet_cnt >= STALL_LIMIT) begin
            $display("FAIL bezier_curve_evaluator");
            $finish;
        end else begin
            quiet_cnt <= quiet_cnt + 1;
        end
    end

    // Stimulus and end of run.
    initial begin
        int unsigned n_eff;
        int unsigned span;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset point_count of 21. Neighboring points sit at
        // opposite extremes so a step between them spans the widest possible difference;
        // every third entry is near zero instead. Then t at zero, one, one half and
        // the all-ones pattern that must saturate to one.
        for (int i = 0; i < 21; i++) begin
            if (i % 3 == 2) begin
                add_load(i, 32'sd0, -32'sd1);
            end else if (i % 2 == 0) begin
                add_load(i, 32'sh7FFF_FFFF, 32'sh8000_0000);
            end else begin
                add_load(i, 32'sh8000_0000, 32'sh7FFF_FFFF);
            end
        end
        add_eval('0);
        add_eval(T_ONE);
        add_eval(17'd32768);
        add_eval('1);

        // Random phases. Each one waits for the block to go idle, writes a new
        // point_count, loads whatever entries the new count reads that were never
        // loaded, then mixes loads to any index with evaluations.
        for (int k = 0; k < N_PHASES; k++) begin
            drain();
            steady          = (k == 3);
            cfg_valid       <= 1'b1;
            cfg_point_count <= COUNT_SEQ[k];
            do @(posedge aclk); while (!cfg_ready);
            count_now = cfg_point_count;
            cfg_valid <= 1'b0;

            n_eff = 32'(COUNT_SEQ[k]);
            if (n_eff < 2) n_eff = 2;
            if (n_eff > NPTS) n_eff = NPTS;
            for (int i = 0; i < n_eff; i++) begin
                if (!gen_loaded[i]) begin
                    add_load(i, pick_coord(), pick_coord());
                end
            end
            // Large counts are slow, so those phases stay short.
            span = (n_eff > 12) ? 30 : 120;
            repeat (span) begin
                if ($urandom_range(0, 99) < 30) begin
                    add_load($urandom_range(0, NPTS - 1), pick_coord(), pick_coord());
                end else begin
                    add_eval(pick_t());
                end
            end
        end

        drain();
        repeat (20) @(posedge aclk);
        if (err_count == 0 && curve_q.size() == 0) begin
            $display("PASS bezier_curve_evaluator");
        end else begin
            $display("FAIL bezier_curve_evaluator");
        end
        $finish;
    end

endmodule
